[rtl/pacd_pkg.sv]
// shared constants and types for the phase accumulator clock divider
`timescale 1ns / 1ps
`default_nettype none

package pacd_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned TimerW    = 16;
  localparam int unsigned GateTapsW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPhaseInc   = 2'd0,
    CfgGateTicks  = 2'd1,
    CfgShortTicks = 2'd2,
    CfgLongTicks  = 2'd3
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] PhaseIncRst   = 32'd2147484;
  localparam logic [TimerW-1:0]   GateTicksRst  = 16'd480;
  localparam logic [TimerW-1:0]   ShortTicksRst = 16'd48;
  localparam logic [TimerW-1:0]   LongTicksRst  = 16'd480;

  typedef logic [TimerW-1:0] timer_t;

endpackage

`default_nettype wire

[rtl/phase_accumulator_clock_divider.sv]
// phase accumulator clock generator with binary divider taps
`timescale 1ns / 1ps
`default_nettype none

// One input transaction is one sample tick carrying the run and reset button
// levels; every tick yields exactly one result transaction. The block takes a
// tick in every cycle unless stalled: the accumulator, step counter and pulse
// timers are registered when the tick is accepted and the result appears in
// the output register in the next cycle. A new tick is accepted whenever the
// output register is empty or its result is being taken in the same cycle,
// so the sustained rate is one tick per cycle while the output is not stalled.
// A rising run edge toggles running and restarts the clock with the longer of
// the short and long reset pulses; a rising reset edge while running restarts
// it with the short pulse. Tap k of gate_taps is the gate pulse while the step
// count is a multiple of 2^k. Configuration writes are taken at any time and
// should be made while the block is idle.
module phase_accumulator_clock_divider #(
  parameter int unsigned TAP_COUNT  = 10,
  parameter int unsigned PHASE_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pacd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pacd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           run_button_i,
  input  wire logic                           reset_button_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pacd_pkg::GateTapsW-1:0]      gate_taps_o,
  output logic                                reset_pulse_o,
  output logic                                running_flag_o
);
  import pacd_pkg::*;

  localparam int unsigned StepW = (TAP_COUNT > 1) ? TAP_COUNT - 1 : 1;
  localparam int unsigned SumW  = ((PHASE_BITS > CfgDataW) ? PHASE_BITS : CfgDataW) + 1;

  function automatic timer_t max_t(input timer_t a, input timer_t b);
    return (a > b) ? a : b;
  endfunction

  // configuration registers
  logic [CfgDataW-1:0] phase_inc_q;
  timer_t              gate_ticks_q;
  timer_t              short_ticks_q;
  timer_t              long_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q   <= PhaseIncRst;
      gate_ticks_q  <= GateTicksRst;
      short_ticks_q <= ShortTicksRst;
      long_ticks_q  <= LongTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPhaseInc:   phase_inc_q   <= cfg_data_i;
        CfgGateTicks:  gate_ticks_q  <= cfg_data_i[TimerW-1:0];
        CfgShortTicks: short_ticks_q <= cfg_data_i[TimerW-1:0];
        CfgLongTicks:  long_ticks_q  <= cfg_data_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  // clock state
  logic                  running_q, running_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [StepW-1:0]      step_q, step_d;
  timer_t                gate_rem_q, gate_rem_d;
  timer_t                reset_rem_q, reset_rem_d;
  logic                  run_prev_q;
  logic                  reset_prev_q, reset_prev_d;

  logic                  in_accept;
  logic                  run_edge;
  logic                  man_edge;
  logic                  restart;
  logic [PHASE_BITS-1:0] phase_base;
  logic [StepW-1:0]      step_base;
  logic [SumW-1:0]       sum;
  logic                  carry;
  timer_t                reset_start;
  timer_t                gate_start;
  logic                  rst_on;
  logic                  gate_on;
  logic [GateTapsW-1:0]  taps;
  logic [15:0]           step_ext;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    run_edge     = run_button_i && !run_prev_q;
    running_d    = running_q ^ run_edge;
    man_edge     = running_d && reset_button_i && !reset_prev_q;
    reset_prev_d = running_d ? reset_button_i : reset_prev_q;
    restart      = run_edge || man_edge;

    phase_base = restart ? '0 : phase_q;
    step_base  = restart ? '0 : step_q;

    sum   = SumW'(phase_base) + SumW'(phase_inc_q);
    carry = running_d && (|sum[SumW-1:PHASE_BITS]);

    phase_d = running_d ? sum[PHASE_BITS-1:0] : phase_base;
    if (carry) begin
      step_d = (TAP_COUNT > 1) ? step_base + StepW'(1) : '0;
    end else begin
      step_d = step_base;
    end

    // run toggle starts both pulses, timer keeps the largest
    reset_start = reset_rem_q;
    if (run_edge) begin
      reset_start = max_t(reset_start, max_t(short_ticks_q, long_ticks_q));
    end
    if (man_edge) begin
      reset_start = max_t(reset_start, short_ticks_q);
    end
    gate_start = carry ? max_t(gate_rem_q, gate_ticks_q) : gate_rem_q;

    rst_on      = (reset_start != '0);
    gate_on     = (gate_start != '0);
    reset_rem_d = rst_on ? reset_start - timer_t'(1) : reset_start;
    gate_rem_d  = gate_on ? gate_start - timer_t'(1) : gate_start;

    step_ext = 16'(step_d);
    taps     = '0;
    for (int k = 0; k < GateTapsW; k++) begin
      if (k < TAP_COUNT) begin
        taps[k] = gate_on && ((step_ext & ((16'd1 << k) - 16'd1)) == 16'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b1;
      phase_q      <= '0;
      step_q       <= '0;
      gate_rem_q   <= '0;
      reset_rem_q  <= '0;
      run_prev_q   <= 1'b0;
      reset_prev_q <= 1'b0;
    end else if (in_accept) begin
      running_q    <= running_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      gate_rem_q   <= gate_rem_d;
      reset_rem_q  <= reset_rem_d;
      run_prev_q   <= run_button_i;
      reset_prev_q <= reset_prev_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_accept) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gate_taps_o    <= taps;
      reset_pulse_o  <= rst_on;
      running_flag_o <= running_d;
    end
  end

`ifndef NO_ASSERTIONS
  // every accepted tick leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted tick produced no result");

  // running only changes when a tick is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(running_q))
    else $error("running state changed without a tick");

  // any active divided tap implies the undivided tap is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (gate_taps_o != '0) |-> gate_taps_o[0])
    else $error("divided tap active without base tap");

  // shown running flag matches the stored state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (running_flag_o == running_q))
    else $error("running flag out of step with state");
`endif

endmodule

`default_nettype wire
